/* rtl/lcte_pkg.sv */
package lcte_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned CapW = 5;
  localparam int unsigned KeyW = 64;
  localparam int unsigned WordW = 32;

  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_AGE  = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_PURGED   = 3'd2;
  localparam logic [2:0] ST_EVICTED  = 3'd3;
  localparam logic [2:0] ST_LOOKUP   = 3'd4;
  localparam logic [2:0] ST_EXPIRED  = 3'd5;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the input item
    logic scan_clr;    // restart the slot sweep
    logic scan_step;   // examine the current slot, advance
    logic purge;       // sweep removes expired entries
    logic evict;       // remove least recent entry found by last sweep
    logic write_hit;   // update found slot
    logic insert;      // write new entry in free slot
    logic lookup;      // finish get/age/tick
  } lcte_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic full;
    logic room;
  } lcte_sts_t;

endpackage

/* rtl/lcte_ctrl.sv */
module lcte_ctrl
  import lcte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic       out_free,
  input  lcte_sts_t  sts,
  output lcte_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_PURGE = 7'b0001000,
    S_EVSC  = 7'b0010000,
    S_EVICT = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  assign in_ready = (state_r == S_IDLE) && out_free;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          op_nxt = op;
          state_nxt = (op == OP_TICK) ? S_FIN : S_FIND;
        end
      end
      S_FIND: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (op_r != OP_PUT) state_nxt = S_FIN;
        else if (sts.hit || !sts.full) state_nxt = S_FIN;
        else begin
          cmd.scan_clr = 1'b1;
          state_nxt = S_PURGE;
        end
      end
      S_PURGE: begin
        cmd.scan_step = 1'b1;
        cmd.purge = 1'b1;
        if (sts.scan_done) state_nxt = S_EVSC;
      end
      S_EVSC: begin
        if (sts.room) state_nxt = S_FIN;
        else begin
          cmd.scan_clr = 1'b1;
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.evict = 1'b1;
          state_nxt = S_EVSC;
        end
      end
      S_FIN: begin
        if (op_r == OP_PUT) begin
          cmd.write_hit = sts.hit;
          cmd.insert = !sts.hit;
        end else begin
          cmd.lookup = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= OP_PUT;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

endmodule

/* rtl/lcte_dp.sv */
module lcte_dp
  import lcte_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_op,
  input  logic [KeyW-1:0]   in_key,
  input  logic [WordW-1:0]  in_value,
  input  logic [WordW-1:0]  in_ttl,
  input  logic [CapW-1:0]   capacity,
  input  lcte_cmd_t         cmd,
  output lcte_sts_t         sts,
  output logic              res_valid,
  input  logic              res_take,
  output logic              res_found,
  output logic [WordW-1:0]  res_read_value,
  output logic [WordW-1:0]  res_age,
  output logic [2:0]        res_status
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [KeyW-1:0]  key_q [ENTRIES];
  logic [WordW-1:0] val_q [ENTRIES];
  logic [WordW-1:0] ttl_q [ENTRIES];
  logic [WordW-1:0] birth_q [ENTRIES];
  logic [IdxW-1:0]  rank_q [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [CntW-1:0] count_r;
  logic [WordW-1:0] now_r;

  logic [1:0] op_r;
  logic [KeyW-1:0] key_r;
  logic [WordW-1:0] value_r, ttl_r;
  logic [IdxW-1:0] scan_r;
  logic scan_end_r;
  logic hit_r, purged_r, evicted_r;
  logic [IdxW-1:0] hit_idx_r, worst_idx_r;
  logic worst_ok_r;

  logic res_valid_r, found_r;
  logic [WordW-1:0] rv_r, age_r;
  logic [2:0] status_r;

  // lowest free slot, priority encode over valid bits
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IdxW'(i);
    end
  end

  // effective capacity clamp
  logic [CntW-1:0] cap_eff;
  always_comb begin
    if (capacity == '0) cap_eff = CntW'(1);
    else if (32'(capacity) > ENTRIES) cap_eff = CntW'(ENTRIES);
    else cap_eff = CntW'(capacity);
  end

  // current slot under the sweep
  logic [WordW-1:0] cur_el, hit_el;
  logic cur_exp, hit_exp, cur_v;
  assign cur_v = valid_r[scan_r];
  assign cur_el = now_r - birth_q[scan_r];
  assign cur_exp = (ttl_q[scan_r] != '0) && (cur_el > ttl_q[scan_r]);
  assign hit_el = now_r - birth_q[hit_idx_r];
  assign hit_exp = (ttl_q[hit_idx_r] != '0) && (hit_el > ttl_q[hit_idx_r]);

  assign sts.scan_done = scan_end_r;
  assign sts.hit = hit_r;
  assign sts.full = count_r >= cap_eff;
  assign sts.room = (count_r < cap_eff) || (count_r == '0);

  // a removal this cycle (purge of current slot, eviction or get expiry)
  // eviction happens on the last sweep step, so the last slot is weighed here too
  logic rm_en;
  logic [IdxW-1:0] rm_idx;
  always_comb begin
    rm_en = 1'b0;
    rm_idx = scan_r;
    if (cmd.scan_step && cmd.purge && cur_v && cur_exp) rm_en = 1'b1;
    if (cmd.evict) begin
      if (cur_v && (!worst_ok_r || rank_q[scan_r] > rank_q[worst_idx_r])) begin
        rm_en = 1'b1;
        rm_idx = scan_r;
      end else if (worst_ok_r) begin
        rm_en = 1'b1;
        rm_idx = worst_idx_r;
      end
    end
    if (cmd.lookup && op_r == OP_GET && hit_r && hit_exp) begin
      rm_en = 1'b1;
      rm_idx = hit_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      now_r <= '0;
      res_valid_r <= 1'b0;
      scan_end_r <= 1'b0;
    end else begin
      if (res_take) res_valid_r <= 1'b0;
      if (cmd.scan_clr) begin
        scan_r <= '0;
        scan_end_r <= 1'b0;
        worst_ok_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_r <= scan_r + IdxW'(1);
        scan_end_r <= (32'(scan_r) == ENTRIES - 2);
        if (cur_v && key_q[scan_r] == key_r && !cmd.purge) begin
          hit_r <= 1'b1;
          hit_idx_r <= scan_r;
        end
        if (cur_v && !(cmd.purge && cur_exp) &&
            (!worst_ok_r || rank_q[scan_r] > rank_q[worst_idx_r])) begin
          worst_ok_r <= 1'b1;
          worst_idx_r <= scan_r;
        end
      end
      if (cmd.load) begin
        op_r <= in_op;
        key_r <= in_key;
        value_r <= in_value;
        ttl_r <= in_ttl;
        hit_r <= 1'b0;
        purged_r <= 1'b0;
        evicted_r <= 1'b0;
      end
      if (cmd.scan_step && cmd.purge) purged_r <= 1'b1;
      if (cmd.evict) evicted_r <= 1'b1;
      if (rm_en) begin
        valid_r[rm_idx] <= 1'b0;
        count_r <= count_r - CntW'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && rank_q[i] > rank_q[rm_idx]) rank_q[i] <= rank_q[i] - IdxW'(1);
        end
      end
      if (cmd.write_hit) begin
        val_q[hit_idx_r] <= value_r;
        ttl_q[hit_idx_r] <= ttl_r;
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && rank_q[i] < rank_q[hit_idx_r]) rank_q[i] <= rank_q[i] + IdxW'(1);
        end
        rank_q[hit_idx_r] <= '0;
        res_valid_r <= 1'b1;
        found_r <= 1'b0;
        rv_r <= '0;
        age_r <= '0;
        status_r <= ST_UPDATED;
      end
      if (cmd.insert) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i]) rank_q[i] <= rank_q[i] + IdxW'(1);
        end
        key_q[free_idx] <= key_r;
        val_q[free_idx] <= value_r;
        ttl_q[free_idx] <= ttl_r;
        birth_q[free_idx] <= now_r;
        rank_q[free_idx] <= '0;
        valid_r[free_idx] <= 1'b1;
        count_r <= count_r + CntW'(1);
        res_valid_r <= 1'b1;
        found_r <= 1'b0;
        rv_r <= '0;
        age_r <= '0;
        status_r <= evicted_r ? ST_EVICTED : (purged_r ? ST_PURGED : ST_INSERTED);
      end
      if (cmd.lookup) begin
        res_valid_r <= 1'b1;
        found_r <= 1'b0;
        rv_r <= '0;
        age_r <= '0;
        status_r <= ST_LOOKUP;
        if (op_r == OP_TICK) now_r <= now_r + 32'd1;
        else if (hit_r) begin
          if (op_r == OP_GET) begin
            if (hit_exp) status_r <= ST_EXPIRED;
            else begin
              found_r <= 1'b1;
              rv_r <= val_q[hit_idx_r];
            end
          end else begin
            age_r <= hit_el;
            found_r <= !hit_exp;
          end
        end
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res_found = found_r;
  assign res_read_value = rv_r;
  assign res_age = age_r;
  assign res_status = status_r;

endmodule

/* rtl/lru_cache_with_ttl_expiry_unit.sv */
// Fully associative key/value cache with per-entry time to live and LRU
// replacement. One transaction at a time. A tick goes straight to the result;
// a get, age query or put that hits or finds room runs one slot sweep, and a
// put into a full cache runs a find sweep, a purge sweep of expired entries
// and then an eviction sweep before each eviction. Each slot sweep examines
// one entry per cycle. The result is held in an output register until taken;
// the next input is accepted once that register is free. capacity (address 0)
// may only be written while idle.
module lru_cache_with_ttl_expiry_unit
  import lcte_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [KeyW-1:0]   in_key,
  input  logic [WordW-1:0]  in_value,
  input  logic [WordW-1:0]  in_ttl,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [WordW-1:0]  out_read_value,
  output logic [WordW-1:0]  out_age,
  output logic [2:0]        out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  lcte_cmd_t cmd;
  lcte_sts_t sts;
  logic [CapW-1:0] cap_r;

  assign pready = 1'b1;
  assign prdata = (paddr[1] == REG_CAPACITY) ? {27'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CapW'(16);
    else if (psel && penable && pwrite && paddr[1] == REG_CAPACITY) cap_r <= pwdata[CapW-1:0];
  end

  lcte_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .op(in_op), .out_free(!out_valid), .sts(sts), .cmd(cmd)
  );

  lcte_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_op(in_op), .in_key(in_key),
    .in_value(in_value), .in_ttl(in_ttl), .capacity(cap_r), .cmd(cmd),
    .sts(sts), .res_valid(out_valid), .res_take(out_ready),
    .res_found(out_found), .res_read_value(out_read_value),
    .res_age(out_age), .res_status(out_status)
  );

endmodule

/* rtl/lcte_checker.sv */
module lcte_checker
  import lcte_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_found,
  input logic [31:0] out_read_value,
  input logic [2:0] out_status
);

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EXPIRED) else $error("bad status");

  a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_status == ST_LOOKUP) else $error("found on put");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_read_value == '0) else $error("stray value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind lru_cache_with_ttl_expiry_unit lcte_checker u_lcte_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
  .out_read_value(out_read_value), .out_status(out_status)
);
